// ===== sv/rcas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and command codes for the calendar clock with alarm.
// No dependencies; imported by every module of the block.
package rcas_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_CHECK  = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;
    localparam logic [1:0] CMD_SNOOZE = 2'd3;

    // Input beat
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] key_code;
        logic       snooze_enabled;
        logic [4:0] new_alarm_hour;
        logic [5:0] new_alarm_minute;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [4:0]  alarm_hour_out;
        logic [5:0]  alarm_minute_out;
        logic        buzzer_active;
        logic        alarm_match;
    } t_out;

    // Clock state; year also kept split as century and year-of-century
    // so the leap test needs only low bits.
    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  cent;
        logic [6:0]  yy;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    // Alarm state
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       buzzer;
    } t_alarm;

endpackage

// ===== sv/rtc_calendar_alarm_snooze_unit.sv =====
`timescale 1ns / 1ps
// Calendar clock with alarm and snooze: top level.
// Two registers: a beat waits in the input register until the result slot is free.
// One beat per cycle while results drain; the input register refills while one waits.
// Reset (i_rst_n low, synchronous): clock 2024-12-13 10:30:00, alarm 10:30, buzzer off,
// both pipeline registers empty. Depends on rcas_pkg, rcas_calendar, rcas_alarm.
module rtc_calendar_alarm_snooze_unit
    import rcas_pkg::*;
#(
    parameter int SNOOZE_MINUTES = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // command beats
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    // result beats
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // Input register: holds one command beat.
    logic   r_in_v;
    t_in    r_in;
    // Architectural state: updated when the held beat moves to the result register.
    t_time  r_time;
    t_alarm r_alarm;
    // Result register.
    logic   r_out_v;
    t_out   r_out;

    t_time  n_time;
    t_time  tick_time;
    t_alarm n_alarm;
    logic   match;
    logic   advance;
    t_out   n_out;

    // Held beat moves forward when the result slot is empty or being drained.
    assign advance    = r_in_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || advance;

    rcas_calendar u_cal (
        .i_cur  (r_time),
        .o_next (tick_time)
    );

    rcas_alarm #(
        .SNOOZE_MINUTES (SNOOZE_MINUTES)
    ) u_alarm (
        .i_cmd    (r_in),
        .i_cur    (r_alarm),
        .i_hour   (r_time.hour),
        .i_minute (r_time.minute),
        .o_next   (n_alarm),
        .o_match  (match)
    );

    // Only a tick moves the clock.
    assign n_time = (r_in.command == CMD_TICK) ? tick_time : r_time;

    always_comb begin
        n_out.cur_year         = n_time.year;
        n_out.cur_month        = n_time.month;
        n_out.cur_day          = n_time.day;
        n_out.cur_hour         = n_time.hour;
        n_out.cur_minute       = n_time.minute;
        n_out.cur_second       = n_time.second;
        n_out.alarm_hour_out   = n_alarm.hour;
        n_out.alarm_minute_out = n_alarm.minute;
        n_out.buzzer_active    = n_alarm.buzzer;
        n_out.alarm_match      = match;
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v         <= 1'b0;
            r_out_v        <= 1'b0;
            r_time.year    <= 14'd2024;
            r_time.cent    <= 7'd20;
            r_time.yy      <= 7'd24;
            r_time.month   <= 4'd12;
            r_time.day     <= 5'd13;
            r_time.hour    <= 5'd10;
            r_time.minute  <= 6'd30;
            r_time.second  <= 6'd0;
            r_alarm.hour   <= 5'd10;
            r_alarm.minute <= 6'd30;
            r_alarm.buzzer <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (advance) begin
                r_out_v <= 1'b1;
                r_time  <= n_time;
                r_alarm <= n_alarm;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ===== sv/rcas_calendar.sv =====
`timescale 1ns / 1ps
// One-second advance of the calendar clock with carries up to the year.
// Depends on rcas_pkg (t_time).
module rcas_calendar
    import rcas_pkg::*;
(
    input  t_time i_cur,
    output t_time o_next
);

    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_wrap;
    logic       leap;
    logic [4:0] mlen;

    // Gregorian rule: a year-of-century of zero defers to the century.
    assign leap = (i_cur.yy != 7'd0) ? (i_cur.yy[1:0] == 2'd0)
                                     : (i_cur.cent[1:0] == 2'd0);

    always_comb begin
        unique case (i_cur.month)
            4'd2:                         mlen = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      mlen = 5'd30;
            default:                      mlen = 5'd31;
        endcase
    end

    assign sec_wrap   = (i_cur.second >= 6'd59);
    assign min_wrap   = sec_wrap && (i_cur.minute >= 6'd59);
    assign hour_wrap  = min_wrap && (i_cur.hour >= 5'd23);
    assign day_wrap   = hour_wrap && (i_cur.day >= mlen);
    assign month_wrap = day_wrap && (i_cur.month >= 4'd12);

    always_comb begin
        o_next = i_cur;
        o_next.second = sec_wrap ? 6'd0 : i_cur.second + 6'd1;
        if (sec_wrap) begin
            o_next.minute = min_wrap ? 6'd0 : i_cur.minute + 6'd1;
        end
        if (min_wrap) begin
            o_next.hour = hour_wrap ? 5'd0 : i_cur.hour + 5'd1;
        end
        if (hour_wrap) begin
            o_next.day = day_wrap ? 5'd1 : i_cur.day + 5'd1;
        end
        if (day_wrap) begin
            o_next.month = month_wrap ? 4'd1 : i_cur.month + 4'd1;
        end
        if (month_wrap) begin
            if (i_cur.year >= 14'd9999) begin
                o_next.year = 14'd0;
                o_next.cent = 7'd0;
                o_next.yy   = 7'd0;
            end else begin
                o_next.year = i_cur.year + 14'd1;
                if (i_cur.yy >= 7'd99) begin
                    o_next.yy   = 7'd0;
                    o_next.cent = i_cur.cent + 7'd1;
                end else begin
                    o_next.yy = i_cur.yy + 7'd1;
                end
            end
        end
    end

endmodule

// ===== sv/rcas_alarm.sv =====
`timescale 1ns / 1ps
// Alarm compare, set, snooze advance and buzzer flag for one command.
// Depends on rcas_pkg (t_in, t_alarm, command codes).
module rcas_alarm
    import rcas_pkg::*;
#(
    parameter int SNOOZE_MINUTES = 5
) (
    input  t_in        i_cmd,
    input  t_alarm     i_cur,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    output t_alarm     o_next,
    output logic       o_match
);

    logic       is_check;
    logic       silence_key;
    logic       advance;
    logic [6:0] min_sum;
    logic       min_carry;
    logic [4:0] hour_inc;

    assign is_check    = (i_cmd.command == CMD_CHECK);
    assign silence_key = i_cmd.snooze_enabled &&
                         (i_cmd.key_code >= 3'd1) && (i_cmd.key_code <= 3'd3);
    assign advance     = (i_cmd.command == CMD_SNOOZE) || (is_check && silence_key);
    assign o_match     = is_check && (i_cur.hour == i_hour) && (i_cur.minute == i_minute);

    // Alarm minute stays below 60, so one subtract covers the wrap.
    assign min_sum   = {1'b0, i_cur.minute} + 7'(SNOOZE_MINUTES);
    assign min_carry = (min_sum >= 7'd60);
    assign hour_inc  = i_cur.hour + {4'd0, min_carry};

    always_comb begin
        o_next = i_cur;
        if (i_cmd.command == CMD_SET) begin
            o_next.hour   = (i_cmd.new_alarm_hour >= 5'd24)
                          ? i_cmd.new_alarm_hour - 5'd24 : i_cmd.new_alarm_hour;
            o_next.minute = (i_cmd.new_alarm_minute >= 6'd60)
                          ? i_cmd.new_alarm_minute - 6'd60 : i_cmd.new_alarm_minute;
        end else if (advance) begin
            o_next.buzzer = 1'b0;
            o_next.minute = min_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];
            o_next.hour   = (hour_inc >= 5'd24) ? 5'd0 : hour_inc;
        end else if (o_match) begin
            o_next.buzzer = 1'b1;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rtc_calendar_alarm_snooze_unit: a calendar and alarm predictor
// scores every result beat against the command beats the block accepted.
// Depends on rcas_pkg and the block's RTL.
module tb;
    import rcas_pkg::*;

    localparam int SNOOZE_STEP = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 37;

    // Calendar/alarm predictor plus the queue of result beats still owed by the block.
    class calendar_scoreboard;
        int year, month, day, hour, minute, second;
        int al_hour, al_minute, buzzer;
        t_out owed_q[$];
        int errors;

        function new();
            year = 2024; month = 12; day = 13;
            hour = 10; minute = 30; second = 0;
            al_hour = 10; al_minute = 30; buzzer = 0;
            errors = 0;
        endfunction

        function int month_days(int m, int y);
            if (m == 2)
                return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // One second, rippling up through the calendar.
        function void tick_clock();
            second++;
            if (second < 60) return;
            second = 0;
            minute++;
            if (minute < 60) return;
            minute = 0;
            hour++;
            if (hour < 24) return;
            hour = 0;
            day++;
            if (day <= month_days(month, year)) return;
            day = 1;
            month++;
            if (month <= 12) return;
            month = 1;
            year = (year >= 9999) ? 0 : year + 1;
        endfunction

        function void push_alarm_later();
            buzzer = 0;
            al_minute += SNOOZE_STEP;
            if (al_minute >= 60) begin
                al_minute -= 60;
                al_hour++;
            end
            al_hour = al_hour % 24;
        endfunction

        function void note_beat(t_in b);
            t_out r;
            int hit;
            hit = 0;
            case (b.command)
                CMD_TICK: begin
                    tick_clock();
                end
                CMD_CHECK: begin
                    if (al_hour == hour && al_minute == minute) begin
                        hit = 1;
                        buzzer = 1;
                    end
                    if (b.snooze_enabled && b.key_code >= 3'd1 && b.key_code <= 3'd3)
                        push_alarm_later();
                end
                CMD_SET: begin
                    al_hour = int'(b.new_alarm_hour);
                    al_minute = int'(b.new_alarm_minute);
                    if (al_hour >= 24) al_hour -= 24;
                    if (al_minute >= 60) al_minute -= 60;
                end
                default: begin
                    push_alarm_later();
                end
            endcase
            r.cur_year = 14'(year);
            r.cur_month = 4'(month);
            r.cur_day = 5'(day);
            r.cur_hour = 5'(hour);
            r.cur_minute = 6'(minute);
            r.cur_second = 6'(second);
            r.alarm_hour_out = 5'(al_hour);
            r.alarm_minute_out = 6'(al_minute);
            r.buzzer_active = 1'(buzzer);
            r.alarm_match = 1'(hit);
            owed_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [13:0] want, logic [13:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                return;
            end
            want = owed_q.pop_front();
            compare_field("cur_year", want.cur_year, got.cur_year);
            compare_field("cur_month", 14'(want.cur_month), 14'(got.cur_month));
            compare_field("cur_day", 14'(want.cur_day), 14'(got.cur_day));
            compare_field("cur_hour", 14'(want.cur_hour), 14'(got.cur_hour));
            compare_field("cur_minute", 14'(want.cur_minute), 14'(got.cur_minute));
            compare_field("cur_second", 14'(want.cur_second), 14'(got.cur_second));
            compare_field("alarm_hour_out", 14'(want.alarm_hour_out),
                          14'(got.alarm_hour_out));
            compare_field("alarm_minute_out", 14'(want.alarm_minute_out),
                          14'(got.alarm_minute_out));
            compare_field("buzzer_active", 14'(want.buzzer_active),
                          14'(got.buzzer_active));
            compare_field("alarm_match", 14'(want.alarm_match), 14'(got.alarm_match));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    bit no_idle = 1'b0;
    int cycle_count = 0;
    calendar_scoreboard sb = new();

    always #4 clk = ~clk;

    rtc_calendar_alarm_snooze_unit dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    // Result side: score accepted beats, stall at random outside the quiet stretch.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rtc_calendar_alarm_snooze_unit regression: fail");
            $finish;
        end
    end

    function automatic t_in beat(logic [1:0] cmd, logic [2:0] key, logic snz,
                                 logic [4:0] hr, logic [5:0] mn);
        t_in b;
        b.command = cmd;
        b.key_code = key;
        b.snooze_enabled = snz;
        b.new_alarm_hour = hr;
        b.new_alarm_minute = mn;
        return b;
    endfunction

    // Mostly ticks and checks; alarms are often aimed at the running clock so
    // that checks actually hit.
    function automatic t_in random_beat();
        t_in b;
        int pick;
        b = beat(CMD_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            b.command = CMD_TICK;
        end else if (pick < 70) begin
            b.command = CMD_CHECK;
        end else if (pick < 88) begin
            b.command = CMD_SET;
            if (pick < 80) begin
                b.new_alarm_hour = 5'(sb.hour);
                b.new_alarm_minute = 6'(sb.minute);
            end
        end else begin
            b.command = CMD_SNOOZE;
        end
        return b;
    endfunction

    task automatic send_beat(input t_in b);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_beat(b);
    endtask

    // Hold off the sender until every owed result beat is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset leaves alarm == clock at 10:30.
        send_beat(beat(CMD_CHECK, 3'd0, 1'b0, 5'd0, 6'd0));   // match, buzzer on
        send_beat(beat(CMD_CHECK, 3'd5, 1'b1, 5'd31, 6'd63)); // key outside 1..3
        send_beat(beat(CMD_CHECK, 3'd2, 1'b0, 5'd0, 6'd0));   // snooze not allowed
        send_beat(beat(CMD_CHECK, 3'd1, 1'b1, 5'd0, 6'd0));   // match and silence together
        send_beat(beat(CMD_TICK, 3'd7, 1'b1, 5'd31, 6'd63));  // unused fields set
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd31, 6'd63));   // both out of range
        send_beat(beat(CMD_SET, 3'd7, 1'b1, 5'd24, 6'd60));   // just out of range
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd23, 6'd59));
        send_beat(beat(CMD_SNOOZE, 3'd0, 1'b0, 5'd0, 6'd0));  // wraps past midnight
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd0, 6'd0));
        send_beat(beat(CMD_SNOOZE, 3'd7, 1'b1, 5'd31, 6'd63));
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd10, 6'd30));
        send_beat(beat(CMD_CHECK, 3'd3, 1'b1, 5'd0, 6'd0));
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd10, 6'd30));
        send_beat(beat(CMD_CHECK, 3'd7, 1'b1, 5'd0, 6'd0));   // key 7 does not silence, buzzer on
        send_beat(beat(CMD_CHECK, 3'd4, 1'b1, 5'd0, 6'd0));
        send_beat(beat(CMD_SNOOZE, 3'd0, 1'b0, 5'd0, 6'd0));  // clears buzzer
        send_beat(beat(CMD_CHECK, 3'd2, 1'b1, 5'd0, 6'd0));   // silence with no match
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd23, 6'd55));
        send_beat(beat(CMD_CHECK, 3'd1, 1'b1, 5'd0, 6'd0));   // alarm to 00:00
        send_beat(beat(CMD_SET, 3'd0, 1'b0, 5'd0, 6'd57));
        send_beat(beat(CMD_SNOOZE, 3'd0, 1'b0, 5'd0, 6'd0));  // minute carry into hour
        send_beat(beat(CMD_CHECK, 3'd0, 1'b1, 5'd0, 6'd0));

        repeat (850) send_beat(random_beat());
        drain_results();

        // Quiet stretch: both sides run flat out.
        no_idle = 1'b1;
        repeat (300) send_beat(random_beat());
        no_idle = 1'b0;

        repeat (850) send_beat(random_beat());

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("rtc_calendar_alarm_snooze_unit regression: pass");
        end else begin
            $display("rtc_calendar_alarm_snooze_unit regression: fail");
        end
        $finish;
    end
endmodule
